// ----- hdl/tpv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain profile visibility package
// Shared constants, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package tpv_pkg;

    localparam int HEIGHT_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 16;

    localparam int OBS_W    = 16;
    localparam int STEP_W   = 24;
    localparam int HORIZ_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

    typedef enum logic [CFG_AW-1:0] {
        REG_OBSERVER_HEIGHT  = 2'd0,
        REG_STEP_LENGTH      = 2'd1,
        REG_HORIZON_DISTANCE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [OBS_W-1:0]   observer_height;
        logic [STEP_W-1:0]  step_length;
        logic [HORIZ_W-1:0] horizon_distance;
    } t_cfg;

endpackage

// ----- hdl/tpv_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain profile visibility configuration registers
// Holds observer height, step length and horizon distance.
// ----------------------------------------------------------------------------
module tpv_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tpv_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tpv_pkg::CFG_W-1:0]  i_cfg_wdata,
    output tpv_pkg::t_cfg              o_cfg
);
    import tpv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_OBSERVER_HEIGHT:  n_cfg.observer_height  = i_cfg_wdata[OBS_W-1:0];
                REG_STEP_LENGTH:      n_cfg.step_length      = i_cfg_wdata[STEP_W-1:0];
                REG_HORIZON_DISTANCE: n_cfg.horizon_distance = i_cfg_wdata[HORIZ_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.observer_height  <= '0;
            r_cfg.step_length      <= STEP_RESET;
            r_cfg.horizon_distance <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/tpv_los_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain profile visibility line-of-sight core
// Running steepest-slope state and the combinational visibility decision.
// ----------------------------------------------------------------------------
module tpv_los_core #(
    parameter int HEIGHT_BITS = tpv_pkg::HEIGHT_BITS_DEF,
    parameter int INDEX_BITS  = tpv_pkg::INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [HEIGHT_BITS-1:0] i_height,
    input  logic                   i_start_profile,
    input  tpv_pkg::t_cfg          i_cfg,
    output logic [INDEX_BITS-1:0]  o_sample_number,
    output logic                   o_visible,
    output logic                   o_beyond_horizon
);
    import tpv_pkg::*;

    localparam int DIST_W = INDEX_BITS + STEP_W;
    localparam int PROD_W = HEIGHT_BITS + INDEX_BITS + 2;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [INDEX_BITS-1:0]         r_index;
    logic                          r_passed;
    logic                          r_have_best;
    logic signed [HEIGHT_BITS:0]   r_best_rise;
    logic [INDEX_BITS-1:0]         r_best_run;

    logic [INDEX_BITS-1:0]         cur_index;
    logic [INDEX_BITS-1:0]         n_index;
    logic                          best_valid;
    logic                          n_passed;
    logic [DIST_W-1:0]             span;
    logic [HEIGHT_BITS+OBS_W-1:0]  obs_wide;
    logic [HEIGHT_BITS-1:0]        obs;
    logic signed [HEIGHT_BITS:0]   rise;
    logic signed [INDEX_BITS:0]    best_run_s;
    logic signed [INDEX_BITS:0]    index_s;
    logic signed [PROD_W-1:0]      prod_new;
    logic signed [PROD_W-1:0]      prod_best;
    logic                          vis;

    assign cur_index  = i_start_profile ? '0 : r_index;
    assign n_index    = (cur_index == INDEX_MAX) ? cur_index
                                                 : cur_index + INDEX_BITS'(1);
    assign best_valid = r_have_best && !i_start_profile;

    assign span     = DIST_W'(n_index) * DIST_W'(i_cfg.step_length);
    assign n_passed = (r_passed && !i_start_profile)
                      || (span > DIST_W'(i_cfg.horizon_distance));

    assign obs_wide = {{HEIGHT_BITS{1'b0}}, i_cfg.observer_height};
    assign obs      = obs_wide[HEIGHT_BITS-1:0];
    assign rise     = $signed({1'b0, i_height}) - $signed({1'b0, obs});

    // Slopes are compared by cross-multiplying; both runs are positive.
    assign best_run_s = $signed({1'b0, r_best_run});
    assign index_s    = $signed({1'b0, n_index});
    assign prod_new   = rise * best_run_s;
    assign prod_best  = r_best_rise * index_s;

    assign vis = !n_passed && (!best_valid || (prod_new > prod_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_passed    <= 1'b0;
            r_have_best <= 1'b0;
        end else if (i_fire) begin
            r_index     <= n_index;
            r_passed    <= n_passed;
            r_have_best <= best_valid || vis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && vis) begin
            r_best_rise <= rise;
            r_best_run  <= n_index;
        end
    end

    assign o_sample_number  = n_index;
    assign o_visible        = vis;
    assign o_beyond_horizon = n_passed;

endmodule

// ----- hdl/terrain_profile_visibility_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain profile visibility unit
// Marks each terrain sample along a profile as visible or hidden from the
// observer and flags samples beyond the horizon distance.
// ----------------------------------------------------------------------------
// The unit takes one height sample per clock cycle when not stalled and returns
// one result per sample; each sample passes through the input register and then
// the result register. The steepest-slope state is updated by a combinational
// cross-multiply compare, which sets this rate.
// Assert start_profile on the first sample of each profile; without it, samples
// continue the current profile. Configuration must be written while the unit
// holds no transaction.
module terrain_profile_visibility_unit #(
    parameter int HEIGHT_BITS = tpv_pkg::HEIGHT_BITS_DEF,
    parameter int INDEX_BITS  = tpv_pkg::INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tpv_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tpv_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [HEIGHT_BITS-1:0]     i_height,
    input  logic                       i_start_profile,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [INDEX_BITS-1:0]      o_sample_number,
    output logic                       o_visible,
    output logic                       o_beyond_horizon
);
    import tpv_pkg::*;

    t_cfg cfg;

    logic                   r_in_valid;
    logic                   n_in_valid;
    logic [HEIGHT_BITS-1:0] r_height;
    logic                   r_start;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [INDEX_BITS-1:0]  r_sample_number;
    logic                   r_visible;
    logic                   r_beyond;

    logic                   out_free;
    logic                   in_free;
    logic                   in_accept;
    logic                   fire;
    logic [INDEX_BITS-1:0]  core_sample_number;
    logic                   core_visible;
    logic                   core_beyond;

    tpv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tpv_los_core #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_height         (r_height),
        .i_start_profile  (r_start),
        .i_cfg            (cfg),
        .o_sample_number  (core_sample_number),
        .o_visible        (core_visible),
        .o_beyond_horizon (core_beyond)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_free;
    assign in_free   = !r_in_valid || out_free;
    assign in_accept = i_valid && in_free;
    assign o_stall   = !in_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_height <= i_height;
            r_start  <= i_start_profile;
        end
        if (fire) begin
            r_sample_number <= core_sample_number;
            r_visible       <= core_visible;
            r_beyond        <= core_beyond;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sample_number  = r_sample_number;
    assign o_visible        = r_visible;
    assign o_beyond_horizon = r_beyond;

endmodule
